### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the work unit queue dispatcher; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define WUQD_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition must never be true outside reset
`define WUQD_NEVER(lbl, clk, rstn, cond, msg) \
	`WUQD_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define WUQD_ASSERT(lbl, clk, rstn, prop, msg)
`define WUQD_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### rtl/core/wuqd_pkg.sv
// ----------------------------------------------------------------------------
// wuqd_pkg
// Shared constants, codes and types of the work unit queue dispatcher.
// ----------------------------------------------------------------------------
package wuqd_pkg;

	// Table geometry
	localparam int SLOTS   = 16;
	localparam int WORKERS = 8;
	localparam int SW      = $clog2(SLOTS);
	localparam int WW      = $clog2(WORKERS);
	localparam int PW      = SW + 1;   // slot pointer, MSB set means null
	localparam int CW      = SW + 1;   // pending count
	localparam int RW      = WW + 1;   // dispatch count

	// Field widths
	localparam int FUNC_W   = 3;
	localparam int CODE_W   = 16;
	localparam int ARG_W    = 32;
	localparam int UNIT_W   = 5;
	localparam int WK_W     = 3;
	localparam int RES_W    = 32;
	localparam int STAT_W   = 3;
	localparam int ACT_W    = 4;
	localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(8);

	localparam logic [PW-1:0] PTR_NIL = {1'b1, {SW{1'b0}}};

	// Commands
	localparam logic [FUNC_W-1:0] FUNC_SUBMIT  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_DONE    = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_POLL    = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_COLLECT = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_CANCEL  = 3'd4;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_UNIT   = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOT_DONE   = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL       = 3'd3;
	localparam logic [STAT_W-1:0] ST_STARTED    = 3'd4;
	localparam logic [STAT_W-1:0] ST_BAD_WORKER = 3'd5;
	localparam logic [STAT_W-1:0] ST_BAD_JOB    = 3'd6;

	localparam logic KIND_REPLY    = 1'b0;
	localparam logic KIND_DISPATCH = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic exec_do;
		logic walk_init;
		logic walk_step;
		logic cfin_do;
		logic disp_do;
		logic disp_adv;
	} wuqd_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
		logic exec_none;
		logic exec_walk;
		logic d_zero;
		logic walk_done;
		logic disp_hit;
		logic disp_last;
	} wuqd_stat_t;

	// One result transaction
	typedef struct packed {
		logic              kind;
		logic [STAT_W-1:0] status;
		logic [UNIT_W-1:0] unit_id;
		logic [WK_W-1:0]   target_worker;
		logic [CODE_W-1:0] out_code;
		logic [ARG_W-1:0]  out_arg;
		logic [RES_W-1:0]  value;
		logic              done_res;
		logic              cancelled;
		logic              queue_busy;
		logic              last;
	} wuqd_out_t;

endpackage

### rtl/core/wuqd_ctrl.sv
// ----------------------------------------------------------------------------
// wuqd_ctrl
// Command sequencer: accept, execute, cancel walk and dispatch pass.
// ----------------------------------------------------------------------------
module wuqd_ctrl
	import wuqd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  wuqd_stat_t stat,
	output wuqd_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_WALK = 5'b00100,
		S_CFIN = 5'b01000,
		S_DISP = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.exec_none) begin
					state_d = S_IDLE;
				end else if (stat.exec_walk) begin
					cmd.walk_init = 1'b1;
					state_d       = S_WALK;
				end else if (stat.out_free) begin
					cmd.exec_do = 1'b1;
					state_d     = stat.d_zero ? S_IDLE : S_DISP;
				end
			end
			S_WALK: begin
				if (stat.walk_done) state_d = S_CFIN;
				else cmd.walk_step = 1'b1;
			end
			S_CFIN: begin
				if (stat.out_free) begin
					cmd.cfin_do = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_DISP: begin
				if (!stat.disp_hit) begin
					cmd.disp_adv = 1'b1;
				end else if (stat.out_free) begin
					cmd.disp_do = 1'b1;
					if (stat.disp_last) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

### rtl/core/wuqd_dp.sv
// ----------------------------------------------------------------------------
// wuqd_dp
// Slot table, free list, pending FIFO, worker table and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module wuqd_dp
	import wuqd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  wuqd_cmd_t         cmd,
	output wuqd_stat_t        stat,
	input  logic [FUNC_W-1:0] func,
	input  logic [CODE_W-1:0] job_code,
	input  logic [ARG_W-1:0]  job_arg,
	input  logic [UNIT_W-1:0] unit,
	input  logic [WK_W-1:0]   worker,
	input  logic [RES_W-1:0]  job_result,
	input  logic [ACT_W-1:0]  active_workers,
	output logic              out_valid,
	input  logic              out_ready,
	output wuqd_out_t         out_item
);

	// Latched command
	logic [FUNC_W-1:0] func_q;
	logic [CODE_W-1:0] code_q;
	logic [ARG_W-1:0]  arg_q;
	logic [UNIT_W-1:0] unit_q;
	logic [WK_W-1:0]   wk_q;
	logic [RES_W-1:0]  res_q;

	// Table state
	logic [SLOTS-1:0]   in_use_q, started_q, done_q;
	logic [PW-1:0]      link_q [SLOTS];
	logic [CODE_W-1:0]  code_mem_q [SLOTS];
	logic [ARG_W-1:0]   arg_mem_q [SLOTS];
	logic [RES_W-1:0]   val_mem_q [SLOTS];
	logic [PW-1:0]      free_q, head_q, tail_q;
	logic [CW-1:0]      pcnt_q;
	logic [WORKERS-1:0] wbusy_q;
	logic [SW-1:0]      wslot_q [WORKERS];
	logic               busy_q;

	// Sequencing state
	logic [PW-1:0] cur_q, prev_q;
	logic [CW-1:0] n_q;
	logic [WW-1:0] w_q;
	logic [RW-1:0] rem_q;

	logic              out_valid_q;
	wuqd_out_t         out_q;

	// Decode
	logic [UNIT_W-1:0]  u_m1;
	logic [SW-1:0]      uidx, fidx, hidx, pidx;
	logic               unit_ok, u_valid, free_nil, wk_ok;
	logic               submit_ok, done_ok, collect_ok, found;
	logic [ACT_W-1:0]   act_eff;
	logic [WORKERS-1:0] amask, wbusy_next, idle_vec;
	logic [RW-1:0]      idle_cnt, d;
	logic [CW-1:0]      pend_next, idle_ext, d_c;
	logic               busy_next;
	logic [PW-1:0]      nxt;
	logic               out_free;
	logic [STAT_W-1:0]  r_status;
	logic [UNIT_W-1:0]  r_unit;
	logic [RES_W-1:0]   r_value;
	logic               r_done;

	assign u_m1     = unit_q - UNIT_W'(1);
	assign uidx     = u_m1[SW-1:0];
	assign unit_ok  = (unit_q != '0) && (unit_q <= UNIT_W'(SLOTS));
	assign u_valid  = unit_ok && in_use_q[uidx];
	assign free_nil = free_q[SW];
	assign fidx     = free_q[SW-1:0];
	assign hidx     = head_q[SW-1:0];
	assign pidx     = prev_q[SW-1:0];
	assign wk_ok    = (int'(wk_q) < WORKERS) && wbusy_q[WW'(wk_q)];
	assign found    = (cur_q == {1'b0, uidx});
	assign nxt      = link_q[uidx];

	assign submit_ok  = (func_q == FUNC_SUBMIT) && (code_q != '0) && !free_nil;
	assign done_ok    = (func_q == FUNC_DONE) && wk_ok;
	assign collect_ok = (func_q == FUNC_COLLECT) && u_valid && done_q[uidx];

	// Clamp worker count to 1..WORKERS
	always_comb begin
		if (active_workers == '0) act_eff = ACT_W'(1);
		else if (int'(active_workers) > WORKERS) act_eff = ACT_W'(WORKERS);
		else act_eff = active_workers;
		for (int w = 0; w < WORKERS; w++) amask[w] = (w < int'(act_eff));
	end

	// Count dispatches that follow a successful submit or worker_done
	always_comb begin
		wbusy_next = wbusy_q;
		if (done_ok) wbusy_next[WW'(wk_q)] = 1'b0;
		pend_next = pcnt_q + CW'(submit_ok);
		idle_vec  = ~wbusy_next & amask;
		idle_cnt  = '0;
		for (int w = 0; w < WORKERS; w++) idle_cnt = idle_cnt + RW'(idle_vec[w]);
		idle_ext = CW'(idle_cnt);
		d_c      = (idle_ext < pend_next) ? idle_ext : pend_next;
		d        = (submit_ok || done_ok) ? RW'(d_c) : '0;
		if (submit_ok || done_ok)
			busy_next = (|wbusy_next) || (d != '0) || (pend_next != d_c);
		else
			busy_next = busy_q;
	end

	// Reply to the latched command
	always_comb begin
		r_status = ST_OK;
		r_unit   = '0;
		r_value  = '0;
		r_done   = 1'b0;
		case (func_q)
			FUNC_SUBMIT: begin
				if (code_q == '0) r_status = ST_BAD_JOB;
				else if (free_nil) r_status = ST_FULL;
				else r_unit = UNIT_W'({1'b0, fidx}) + UNIT_W'(1);
			end
			FUNC_DONE: begin
				if (!wk_ok) r_status = ST_BAD_WORKER;
			end
			FUNC_POLL: begin
				if (!u_valid) begin
					r_status = ST_BAD_UNIT;
					r_done   = 1'b1;
				end else begin
					r_done = done_q[uidx];
				end
			end
			FUNC_COLLECT: begin
				if (!u_valid) r_status = ST_BAD_UNIT;
				else if (!done_q[uidx]) r_status = ST_NOT_DONE;
				else r_value = val_mem_q[uidx];
			end
			FUNC_CANCEL: begin
				if (!u_valid) r_status = ST_BAD_UNIT;
				else r_status = ST_STARTED;
			end
			default: r_status = ST_OK;
		endcase
	end

	assign out_free = !out_valid_q || out_ready;

	// Status to the controller
	always_comb begin
		stat.out_free  = out_free;
		stat.exec_none = (func_q != FUNC_SUBMIT) && (func_q != FUNC_DONE) &&
			(func_q != FUNC_POLL) && (func_q != FUNC_COLLECT) && (func_q != FUNC_CANCEL);
		stat.exec_walk = (func_q == FUNC_CANCEL) && u_valid && !started_q[uidx];
		stat.d_zero    = (d == '0);
		stat.walk_done = found || cur_q[SW] || (n_q == CW'(SLOTS));
		stat.disp_hit  = !wbusy_q[w_q] && amask[w_q];
		stat.disp_last = (rem_q == RW'(1));
	end

	// Latch the accepted command
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= func;
			code_q <= job_code;
			arg_q  <= job_arg;
			unit_q <= unit;
			wk_q   <= worker;
			res_q  <= job_result;
		end
	end

	// Slot payload and worker slot numbers
	always_ff @(posedge clk) begin
		if (cmd.exec_do && submit_ok) begin
			code_mem_q[fidx] <= code_q;
			arg_mem_q[fidx]  <= arg_q;
		end
		if (cmd.exec_do && done_ok) val_mem_q[wslot_q[WW'(wk_q)]] <= res_q;
		if (cmd.disp_do) wslot_q[w_q] <= hidx;
	end

	// Lists, flags and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q  <= '0;
			started_q <= '0;
			done_q    <= '0;
			for (int i = 0; i < SLOTS; i++)
				link_q[i] <= (i + 1 < SLOTS) ? PW'(i + 1) : PTR_NIL;
			free_q  <= '0;
			head_q  <= PTR_NIL;
			tail_q  <= PTR_NIL;
			pcnt_q  <= '0;
			wbusy_q <= '0;
			busy_q  <= 1'b0;
			cur_q   <= PTR_NIL;
			prev_q  <= PTR_NIL;
			n_q     <= '0;
			w_q     <= '0;
			rem_q   <= '0;
		end else begin
			if (cmd.exec_do) begin
				busy_q <= busy_next;
				rem_q  <= d;
				w_q    <= '0;
				// append a new job to the pending FIFO
				if (submit_ok) begin
					free_q          <= link_q[fidx];
					in_use_q[fidx]  <= 1'b1;
					started_q[fidx] <= 1'b0;
					done_q[fidx]    <= 1'b0;
					link_q[fidx]    <= PTR_NIL;
					if (!tail_q[SW]) link_q[tail_q[SW-1:0]] <= free_q;
					else head_q <= free_q;
					tail_q <= free_q;
					pcnt_q <= pcnt_q + CW'(1);
				end
				// mark completion and free the worker
				if (done_ok) begin
					done_q[wslot_q[WW'(wk_q)]] <= 1'b1;
					wbusy_q[WW'(wk_q)]         <= 1'b0;
				end
				// release a collected slot
				if (collect_ok) begin
					in_use_q[uidx] <= 1'b0;
					link_q[uidx]   <= free_q;
					free_q         <= {1'b0, uidx};
				end
			end
			if (cmd.walk_init) begin
				cur_q  <= head_q;
				prev_q <= PTR_NIL;
				n_q    <= '0;
			end
			if (cmd.walk_step) begin
				prev_q <= cur_q;
				cur_q  <= link_q[cur_q[SW-1:0]];
				n_q    <= n_q + CW'(1);
			end
			// unlink the cancelled job and release its slot
			if (cmd.cfin_do && found) begin
				if (prev_q[SW]) head_q <= nxt;
				else link_q[pidx] <= nxt;
				if (nxt[SW]) tail_q <= prev_q;
				in_use_q[uidx] <= 1'b0;
				link_q[uidx]   <= free_q;
				free_q         <= {1'b0, uidx};
				pcnt_q         <= pcnt_q - CW'(1);
			end
			// hand the FIFO head to the current worker
			if (cmd.disp_do) begin
				head_q <= link_q[hidx];
				if (link_q[hidx][SW]) tail_q <= PTR_NIL;
				link_q[hidx]    <= PTR_NIL;
				started_q[hidx] <= 1'b1;
				wbusy_q[w_q]    <= 1'b1;
				pcnt_q          <= pcnt_q - CW'(1);
				rem_q           <= rem_q - RW'(1);
				w_q             <= w_q + WW'(1);
			end
			if (cmd.disp_adv) w_q <= w_q + WW'(1);
		end
	end

	// Result register: load a transaction, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.exec_do || cmd.cfin_do || cmd.disp_do) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec_do) begin
			out_q               <= '0;
			out_q.kind          <= KIND_REPLY;
			out_q.status        <= r_status;
			out_q.unit_id       <= r_unit;
			out_q.value         <= r_value;
			out_q.done_res      <= r_done;
			out_q.queue_busy    <= busy_next;
			out_q.last          <= (d == '0);
		end else if (cmd.cfin_do) begin
			out_q               <= '0;
			out_q.kind          <= KIND_REPLY;
			out_q.status        <= found ? ST_OK : ST_BAD_UNIT;
			out_q.cancelled     <= found;
			out_q.queue_busy    <= busy_q;
			out_q.last          <= 1'b1;
		end else if (cmd.disp_do) begin
			out_q               <= '0;
			out_q.kind          <= KIND_DISPATCH;
			out_q.status        <= ST_OK;
			out_q.unit_id       <= UNIT_W'({1'b0, hidx}) + UNIT_W'(1);
			out_q.target_worker <= WK_W'(w_q);
			out_q.out_code      <= code_mem_q[hidx];
			out_q.out_arg       <= arg_mem_q[hidx];
			out_q.queue_busy    <= busy_q;
			out_q.last          <= (rem_q == RW'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`WUQD_ASSERT(a_pcnt_range, clk, arst_n, pcnt_q <= CW'(SLOTS), "pending count above table size")
	`WUQD_ASSERT(a_head_tail, clk, arst_n, head_q[SW] == tail_q[SW], "FIFO head and tail disagree")
	`WUQD_ASSERT(a_head_cnt, clk, arst_n, head_q[SW] == (pcnt_q == '0), "FIFO head and count disagree")
	`WUQD_NEVER(a_disp_rem, clk, arst_n, cmd.disp_do && (rem_q == '0), "dispatch beyond count")
	`WUQD_NEVER(a_load_free, clk, arst_n, (cmd.exec_do || cmd.cfin_do || cmd.disp_do) && !out_free,
		"result register overwritten")

endmodule

### rtl/core/work_unit_queue_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// work_unit_queue_dispatcher_unit
// Job slot table with free list, pending FIFO and worker dispatch.
// ----------------------------------------------------------------------------
// Commands (submit, worker_done, poll, collect, cancel) enter on the s_axis
// channel, func in s_tuser. Results leave on m_axis: a reply first, then one
// dispatch transaction per job handed to an idle worker (m_tuser high), in
// worker order; m_tlast marks the final result of a command.
// One command is in work at a time. The reply is loaded into the result
// register in the execute state, or after the walk for a cancel; a dispatch
// pass scans the workers one per cycle, waiting while the result register is
// not free; a cancel walks the pending list one link per cycle, up to SLOTS
// steps. An unknown func gets no result. active_workers lies at APB address 0.
// Reset empties the table, chains all slots into the free list, idles all
// workers and sets active_workers to 8. When the receiver stalls, the result
// register holds and the sequencer waits; no result is dropped.
// ----------------------------------------------------------------------------
module work_unit_queue_dispatcher_unit
	import wuqd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // job_code[15:0], job_arg[47:16], unit[52:48],
	                              // worker[55:53], job_result[87:56]
	input  logic [2:0]  s_tuser,  // func[2:0]
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,  // status[2:0], unit_id[7:3], target_worker[10:8],
	                              // out_code[26:11], out_arg[58:27], value[90:59],
	                              // done_res[91], cancelled[92], queue_busy[93], zero
	output logic [0:0]  m_tuser,  // kind[0]
	output logic        m_tlast
);

	logic [ACT_W-1:0] act_q;
	wuqd_cmd_t        cmd;
	wuqd_stat_t       stat;
	wuqd_out_t        item;

	// Configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) act_q <= ACT_RESET;
		else if (psel && penable && pwrite && !paddr[2]) act_q <= pwdata[ACT_W-1:0];
	end
	assign prdata = paddr[2] ? 32'd0 : {{(32 - ACT_W){1'b0}}, act_q};

	wuqd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	wuqd_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.func           (s_tuser),
		.job_code       (s_tdata[15:0]),
		.job_arg        (s_tdata[47:16]),
		.unit           (s_tdata[52:48]),
		.worker         (s_tdata[55:53]),
		.job_result     (s_tdata[87:56]),
		.active_workers (act_q),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_item       (item)
	);

	// Pack the result transaction
	assign m_tdata = {2'b00, item.queue_busy, item.cancelled, item.done_res, item.value,
		item.out_arg, item.out_code, item.target_worker, item.unit_id, item.status};
	assign m_tuser = item.kind;
	assign m_tlast = item.last;

endmodule
